// ----- hdl/gqv_pkg.sv -----
`timescale 1ns / 1ps

package gqv_pkg;

  // Field widths of the channels.
  localparam int CODE_W  = 8;
  localparam int POS_W   = 32;
  localparam int TEX_U_W = 6;
  localparam int TEX_V_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SCALE_W    = 12;

  // Character codes with a meaning of their own.
  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0] FIRST_GLYPH  = 8'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SCALE = 2'd2;

  // Quad corners in the order they are sent (two triangles).
  typedef enum logic [2:0] {
    CORNER_TL_A = 3'd0,
    CORNER_BL   = 3'd1,
    CORNER_BR_A = 3'd2,
    CORNER_TL_B = 3'd3,
    CORNER_BR_B = 3'd4,
    CORNER_TR   = 3'd5
  } corner_t;

  // Texture corners of one atlas cell.
  typedef struct packed {
    logic [TEX_U_W-1:0] u1;
    logic [TEX_U_W-1:0] u2;
    logic [TEX_V_W-1:0] v1;
    logic [TEX_V_W-1:0] v2;
  } tex_t;

  typedef tex_t [255:0] tex_lut_t;

  // One glyph quad, ready to be sent corner by corner.
  typedef struct packed {
    logic [POS_W-1:0] x0;
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y0;
    logic [POS_W-1:0] y1;
    tex_t             tex;
    logic             bad;
  } quad_t;

  // Signed plus non-negative, clipped at the top of the signed 32 bit range.
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {a[POS_W-1], a} + {1'b0, b};
    if (!s[POS_W] && s[POS_W-1]) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
    return s[POS_W-1:0];
  endfunction

endpackage

// ----- hdl/gqv_if.sv -----
`timescale 1ns / 1ps

// Character channel.
interface gqv_in_if;
  logic                           valid;
  logic                           ready;
  logic [gqv_pkg::CODE_W-1:0]     char_code;
  logic                           text_start;

  modport source (output valid, char_code, text_start, input ready);
  modport sink   (input valid, char_code, text_start, output ready);
endinterface

// Vertex channel.
interface gqv_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [gqv_pkg::POS_W-1:0] pos_x;
  logic signed [gqv_pkg::POS_W-1:0] pos_y;
  logic [gqv_pkg::TEX_U_W-1:0]    tex_u;
  logic [gqv_pkg::TEX_V_W-1:0]    tex_v;
  logic                           bad_code;
  logic                           last_vertex;

  modport source (output valid, pos_x, pos_y, tex_u, tex_v, bad_code, last_vertex,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, tex_u, tex_v, bad_code, last_vertex,
                  output ready);
endinterface

// Register write channel.
interface gqv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gqv_pkg::CFG_IDX_W-1:0]    index;
  logic [gqv_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/gqv_corner_seq.sv -----
`timescale 1ns / 1ps

// Holds one quad and sends its six corners, one word per cycle while the
// receiver takes them, through an output register.
module gqv_corner_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  output logic             load_ready,
  input  gqv_pkg::quad_t   quad,
  gqv_out_if.source        out_if
);

  logic             q_v_r, q_v_nxt;
  gqv_pkg::quad_t   quad_r, quad_nxt;
  gqv_pkg::corner_t corner_r, corner_nxt;
  logic             out_v_r, out_v_nxt;
  logic [gqv_pkg::POS_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [gqv_pkg::TEX_U_W-1:0] tu_r, tu_nxt;
  logic [gqv_pkg::TEX_V_W-1:0] tv_r, tv_nxt;
  logic             bad_r, bad_nxt, last_r, last_nxt;
  logic             step, is_last, load, hi_x, hi_y;

  // A corner moves forward when the output register is free or drains.
  assign step       = q_v_r && (!out_v_r || out_if.ready);
  assign is_last    = (corner_r == gqv_pkg::CORNER_TR);
  assign load_ready = !q_v_r || (step && is_last);
  assign load       = load_valid && load_ready;

  // Which edge of the quad the current corner sits on.
  always_comb begin
    case (corner_r)
      gqv_pkg::CORNER_TL_A: begin hi_x = 1'b0; hi_y = 1'b1; end
      gqv_pkg::CORNER_BL:   begin hi_x = 1'b0; hi_y = 1'b0; end
      gqv_pkg::CORNER_BR_A: begin hi_x = 1'b1; hi_y = 1'b0; end
      gqv_pkg::CORNER_TL_B: begin hi_x = 1'b0; hi_y = 1'b1; end
      gqv_pkg::CORNER_BR_B: begin hi_x = 1'b1; hi_y = 1'b0; end
      gqv_pkg::CORNER_TR:   begin hi_x = 1'b1; hi_y = 1'b1; end
      default:              begin hi_x = 1'b0; hi_y = 1'b0; end
    endcase
  end

  // Next values of the quad holder and the output register.
  always_comb begin
    q_v_nxt    = q_v_r;
    quad_nxt   = quad_r;
    corner_nxt = corner_r;
    out_v_nxt  = out_v_r && !out_if.ready;
    px_nxt     = px_r;
    py_nxt     = py_r;
    tu_nxt     = tu_r;
    tv_nxt     = tv_r;
    bad_nxt    = bad_r;
    last_nxt   = last_r;
    if (step) begin
      out_v_nxt  = 1'b1;
      px_nxt     = hi_x ? quad_r.x1 : quad_r.x0;
      py_nxt     = hi_y ? quad_r.y1 : quad_r.y0;
      tu_nxt     = hi_x ? quad_r.tex.u2 : quad_r.tex.u1;
      tv_nxt     = hi_y ? quad_r.tex.v1 : quad_r.tex.v2;
      bad_nxt    = quad_r.bad;
      last_nxt   = is_last;
      corner_nxt = gqv_pkg::corner_t'(corner_r + 3'd1);
      if (is_last) begin
        q_v_nxt = 1'b0;
      end
    end
    if (load) begin
      q_v_nxt    = 1'b1;
      quad_nxt   = quad;
      corner_nxt = gqv_pkg::CORNER_TL_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r    <= 1'b0;
      corner_r <= gqv_pkg::CORNER_TL_A;
      out_v_r  <= 1'b0;
    end else begin
      q_v_r    <= q_v_nxt;
      corner_r <= corner_nxt;
      out_v_r  <= out_v_nxt;
    end
    quad_r <= quad_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    tu_r   <= tu_nxt;
    tv_r   <= tv_nxt;
    bad_r  <= bad_nxt;
    last_r <= last_nxt;
  end

  assign out_if.valid       = out_v_r;
  assign out_if.pos_x       = px_r;
  assign out_if.pos_y       = py_r;
  assign out_if.tex_u       = tu_r;
  assign out_if.tex_v       = tv_r;
  assign out_if.bad_code    = bad_r;
  assign out_if.last_vertex = last_r;

endmodule

// ----- hdl/glyph_quad_vertex_generator_unit.sv -----
`timescale 1ns / 1ps

// Turns a stream of character bytes into textured triangle vertices.
// Input channel (in_if): one character word, with text_start to put the pen
// back to the origin before it. A newline moves the pen to the origin column
// and one glyph height down and sends nothing; any other code sends six
// vertices (two triangles), the sixth marked by last_vertex.
// Output channel (out_if): one vertex word per cycle while the receiver takes
// them. Configuration channel (cfg_if): origin and glyph scale, always ready;
// the user must write it only while no character is in flight; the block
// itself does not enforce this. A character passes through the input
// register, the quad holder of the corner sequencer and the output register.
// A printable character leaves as six vertices from the corner sequencer,
// one vertex per cycle while the receiver takes them; a newline leaves the
// input register without waiting on the sequencer. The next character is
// taken into the input register while the current quad is still being sent.
// Reset puts the origin at zero, the scale at 1.0 and the pen at zero, and
// empties all stages. When the receiver stalls, the output register holds
// its vertex and the stages behind it fill and drop ready.
module glyph_quad_vertex_generator_unit #(
  parameter int GLYPH_WIDTH   = 16,
  parameter int GLYPH_HEIGHT  = 16,
  parameter int ATLAS_COLUMNS = 32,
  parameter int ATLAS_ROWS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  gqv_in_if.sink     in_if,
  gqv_out_if.source  out_if,
  gqv_cfg_if.sink    cfg_if
);

  localparam int GLYPH_MAX = (GLYPH_WIDTH > GLYPH_HEIGHT) ? GLYPH_WIDTH : GLYPH_HEIGHT;
  localparam int DIM_W     = gqv_pkg::SCALE_W + $clog2(GLYPH_MAX + 1);
  localparam int POS_W     = gqv_pkg::POS_W;

  // Atlas cell corners for every byte; control codes use the space cell.
  function automatic gqv_pkg::tex_lut_t build_tex_lut();
    gqv_pkg::tex_lut_t t;
    int idx, col, row;
    for (int c = 0; c < 256; c++) begin
      idx = (c < 32) ? 0 : c - 32;
      col = idx % ATLAS_COLUMNS;
      row = (idx / ATLAS_COLUMNS) % ATLAS_ROWS;
      t[c].u1 = gqv_pkg::TEX_U_W'(col);
      t[c].u2 = gqv_pkg::TEX_U_W'(col + 1);
      t[c].v1 = gqv_pkg::TEX_V_W'(ATLAS_ROWS - 1 - row);
      t[c].v2 = gqv_pkg::TEX_V_W'(ATLAS_ROWS - row);
    end
    return t;
  endfunction

  localparam gqv_pkg::tex_lut_t TEX_LUT = build_tex_lut();

  // Configuration registers; the scale is kept as quad width and height.
  logic [15:0]      ox_r, ox_nxt, oy_r, oy_nxt;
  logic [DIM_W-1:0] w_r, w_nxt, h_r, h_nxt;

  // Input register.
  logic               s0_v_r, s0_v_nxt;
  logic               s0_start_r, s0_nl_r, s0_bad_r;
  gqv_pkg::tex_t      s0_tex_r;
  logic               s0_take, in_acc;

  // Pen.
  logic [POS_W-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic [POS_W-1:0] ox_fix, oy_fix, base_x, base_y, x1, y1;

  logic           q_load_valid, q_load_ready;
  gqv_pkg::quad_t q_load;

  assign cfg_if.ready = 1'b1;

  // Register writes.
  always_comb begin
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    w_nxt  = w_r;
    h_nxt  = h_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        gqv_pkg::REG_ORIGIN_X: ox_nxt = cfg_if.data;
        gqv_pkg::REG_ORIGIN_Y: oy_nxt = cfg_if.data;
        gqv_pkg::REG_GLYPH_SCALE: begin
          w_nxt = DIM_W'(cfg_if.data[gqv_pkg::SCALE_W-1:0] * GLYPH_WIDTH);
          h_nxt = DIM_W'(cfg_if.data[gqv_pkg::SCALE_W-1:0] * GLYPH_HEIGHT);
        end
        default: ;
      endcase
    end
  end

  // The input register takes a word when empty or when its word moves on.
  assign s0_take      = s0_v_r && (s0_nl_r || q_load_ready);
  assign in_if.ready  = !s0_v_r || s0_take;
  assign in_acc       = in_if.valid && in_if.ready;
  assign s0_v_nxt     = in_acc || (s0_v_r && !s0_take);
  assign q_load_valid = s0_v_r && !s0_nl_r;

  // Pen arithmetic: whole pixel origin into 1/256 pixel units.
  assign ox_fix = {{8{ox_r[15]}}, ox_r, 8'h00};
  assign oy_fix = {{8{oy_r[15]}}, oy_r, 8'h00};
  assign base_x = s0_start_r ? ox_fix : pen_x_r;
  assign base_y = s0_start_r ? oy_fix : pen_y_r;
  assign x1     = gqv_pkg::sat_add(base_x, POS_W'(w_r));
  assign y1     = gqv_pkg::sat_add(base_y, POS_W'(h_r));

  assign q_load.x0  = base_x;
  assign q_load.x1  = x1;
  assign q_load.y0  = base_y;
  assign q_load.y1  = y1;
  assign q_load.tex = s0_tex_r;
  assign q_load.bad = s0_bad_r;

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (s0_take) begin
      if (s0_nl_r) begin
        pen_x_nxt = ox_fix;
        pen_y_nxt = y1;
      end else begin
        pen_x_nxt = x1;
        pen_y_nxt = base_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r    <= '0;
      oy_r    <= '0;
      w_r     <= DIM_W'(256 * GLYPH_WIDTH);
      h_r     <= DIM_W'(256 * GLYPH_HEIGHT);
      s0_v_r  <= 1'b0;
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      s0_v_r  <= s0_v_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
    if (in_acc) begin
      s0_start_r <= in_if.text_start;
      s0_nl_r    <= (in_if.char_code == gqv_pkg::NEWLINE_CODE);
      s0_bad_r   <= (in_if.char_code < gqv_pkg::FIRST_GLYPH) &&
                    (in_if.char_code != gqv_pkg::NEWLINE_CODE);
      s0_tex_r   <= TEX_LUT[in_if.char_code];
    end
  end

  gqv_corner_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (q_load_valid),
    .load_ready (q_load_ready),
    .quad       (q_load),
    .out_if     (out_if)
  );

  // An accepted character is held in the input register on the next cycle.
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s0_v_r)
    else $error("accepted character lost from input register");

  // A glyph without text_start never moves the pen to the left.
  a_pen_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_take && !s0_nl_r && !s0_start_r) |=>
      ($signed(pen_x_r) >= $signed($past(pen_x_r))))
    else $error("pen moved backward on a glyph");

  // A newline puts the pen back on the origin column.
  a_nl_col: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_take && s0_nl_r) |=> (pen_x_r == $past(ox_fix)))
    else $error("newline did not return pen to origin column");

endmodule
